/* rtl/core/cmst_pkg.sv */
// ----------------------------------------------------------------------------
// cmst_pkg
// Shared types and constants for the compare-match system timer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmst_pkg;

   // Channel count limits
   localparam int MAX_CHANNELS         = 4;
   localparam int NUM_CHANNELS_DEFAULT = 4;
   localparam int IRQ_W                = 4;

   // Register map (byte offsets)
   localparam logic [11:0] OFS_STATUS = 12'h000;
   localparam logic [11:0] OFS_LOW    = 12'h004;
   localparam logic [11:0] OFS_HIGH   = 12'h008;
   localparam logic [11:0] OFS_CMP0   = 12'h00c;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_IDLE  = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0]      read_data;
      logic             bad_offset;
      logic [IRQ_W-1:0] irq_lines;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/compare_match_system_timer_core.sv */
// ----------------------------------------------------------------------------
// compare_match_system_timer_core
// Free-running 64-bit microsecond counter with compare-match channels.
// ----------------------------------------------------------------------------
//
// Each request is a tick, a bus read, a bus write or an idle step, and each
// request yields exactly one response carrying read data, a bad-offset flag
// and the current interrupt lines. While the response side does not stall,
// the block takes one request per clock and holds a sustained rate of one
// response per clock. A request passes through the request register and then
// the response register, with the counter increment, the register decode and
// all channel compares done combinationally between them. A stalled response
// holds the response register, and the request register then holds too, so
// the request side stalls only while both stages are full. Reset clears the
// counter, the compares and the match bits; no compare is made until the
// first tick or accepted write. Writes to the read-only counter words, to
// unused channels or to unmapped offsets report bad_offset and change nothing.
//
`default_nettype none

module compare_match_system_timer_core #(
   parameter int NUM_CHANNELS = cmst_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cmst_pkg::req_type req_data,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cmst_pkg::rsp_type      rsp_data
);

   // Request stage
   logic              req_valid_ff, req_valid_in;
   cmst_pkg::req_type req_ff;

   // Response stage
   logic              rsp_valid_ff, rsp_valid_in;
   cmst_pkg::rsp_type rsp_ff, rsp_in;

   // Timer state
   logic [63:0]             cnt_ff, cnt_in;
   logic [31:0]             cmp_ff [NUM_CHANNELS];
   logic [31:0]             cmp_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] match_ff, match_in;

   logic                    advance;
   logic                    do_cmp;
   logic [NUM_CHANNELS-1:0] cmp_hit;
   logic [31:0]             cmp_rd;

   // Request moves to the response stage when that stage is free or draining.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_valid_in = (req_valid && !req_stall) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Compare offset decode and read mux, one slot per channel
   always_comb begin
      cmp_rd = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         cmp_hit[i] = (req_ff.reg_offset == 12'(cmst_pkg::OFS_CMP0 + 12'(4 * i)));
         if (cmp_hit[i]) begin
            cmp_rd = cmp_rd | cmp_ff[i];
         end
      end
   end

   // Next state and response
   always_comb begin
      cnt_in   = cnt_ff;
      cmp_in   = cmp_ff;
      match_in = match_ff;
      do_cmp   = 1'b0;
      rsp_in.read_data  = '0;
      rsp_in.bad_offset = 1'b0;

      if (advance) begin
         case (req_ff.action)
            cmst_pkg::ACT_TICK: begin
               cnt_in = cnt_ff + 64'd1;
               do_cmp = 1'b1;
            end
            cmst_pkg::ACT_READ: begin
               if (req_ff.reg_offset == cmst_pkg::OFS_STATUS) begin
                  rsp_in.read_data = 32'(match_ff);
               end else if (req_ff.reg_offset == cmst_pkg::OFS_LOW) begin
                  rsp_in.read_data = cnt_ff[31:0];
               end else if (req_ff.reg_offset == cmst_pkg::OFS_HIGH) begin
                  rsp_in.read_data = cnt_ff[63:32];
               end else if (|cmp_hit) begin
                  rsp_in.read_data = cmp_rd;
               end else begin
                  rsp_in.bad_offset = 1'b1;
               end
            end
            cmst_pkg::ACT_WRITE: begin
               if (req_ff.reg_offset == cmst_pkg::OFS_STATUS) begin
                  // write one to clear
                  match_in = match_ff & ~req_ff.write_data[NUM_CHANNELS-1:0];
                  do_cmp   = 1'b1;
               end else if (|cmp_hit) begin
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     if (cmp_hit[i]) begin
                        cmp_in[i] = req_ff.write_data;
                     end
                  end
                  do_cmp = 1'b1;
               end else begin
                  rsp_in.bad_offset = 1'b1;
               end
            end
            default: begin
               // idle step
            end
         endcase
      end

      // Compares see the updated counter and compare values
      if (do_cmp) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (cmp_in[i] == cnt_in[31:0]) begin
               match_in[i] = 1'b1;
            end
         end
      end

      rsp_in.irq_lines = cmst_pkg::IRQ_W'(match_in);
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         match_ff     <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cmp_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         match_ff     <= match_in;
         cmp_ff       <= cmp_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_rsp_after_advance : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("response not valid after request advanced");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> !req_stall)
      else $error("request stalled with empty request stage");

   a_tick_counts : assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.action == cmst_pkg::ACT_TICK) |=>
         (cnt_ff == $past(cnt_ff) + 64'd1))
      else $error("tick did not advance counter");

   a_read_keeps_match : assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.action == cmst_pkg::ACT_READ) |=>
         ($stable(match_ff) && $stable(cnt_ff)))
      else $error("read changed timer state");

   a_irq_unused_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.irq_lines >> NUM_CHANNELS) == '0))
      else $error("irq line of unused channel set");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compare-match system timer core. Requests are
// sent over the valid/stall port while a scoreboard in the bench tracks the
// counter, the compares and the match bits. Every response is checked field
// by field against the oldest predicted response. The run covers directed
// reset-value, register-map and match/clear cases, then random traffic under
// several idle/stall mixes, plus a long response hold-off that backs up the pipe.
// ----------------------------------------------------------------------------
module tb;

   localparam int         CHANNELS     = cmst_pkg::NUM_CHANNELS_DEFAULT;
   localparam logic [3:0] CHAN_MASK    = 4'((1 << CHANNELS) - 1);
   localparam int         CYCLE_LIMIT  = 200000;  // far above the slowest legal run
   localparam int         DRAIN_CYCLES = 8;       // two-stage pipe, plenty of slack
   localparam int         HOLD_CYCLES  = 300;     // long response hold-off

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cmst_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cmst_pkg::rsp_type rsp_data;

   // idle mix, percent of cycles
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // hold-off handshake: the stimulus bumps the request count, the response
   // process notices the change and counts the hold-off itself
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   int fail_count  = 0;
   int cycle_count = 0;

   cmst_pkg::rsp_type pending_rsp[$];  // predicted responses, oldest first

   // scoreboard copy of the timer state
   logic [63:0] tmr_count;
   logic [31:0] tmr_compare [CHANNELS];
   logic [3:0]  tmr_match;

   compare_match_system_timer_core #(
      .NUM_CHANNELS(CHANNELS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Scoreboard model
   // ------------------------------------------------------------------------

   // channel index for a compare offset, -1 when the offset is not one
   // (below the compare block, misaligned, or past the last channel)
   function automatic int compare_channel(logic [11:0] ofs);
      logic [11:0] idx;
      if (ofs < cmst_pkg::OFS_CMP0 || ofs[1:0] != 2'b00) return -1;
      idx = (ofs - cmst_pkg::OFS_CMP0) >> 2;
      if (idx >= CHANNELS) return -1;
      return int'(idx);
   endfunction

   // every tick and accepted write latches channels equal to the low word
   function automatic void latch_matches();
      for (int i = 0; i < CHANNELS; i++)
         if (tmr_compare[i] == tmr_count[31:0]) tmr_match[i] = 1'b1;
      tmr_match &= CHAN_MASK;
   endfunction

   // advances the scoreboard by one request and returns its response
   function automatic cmst_pkg::rsp_type timer_predict(cmst_pkg::req_type r);
      cmst_pkg::rsp_type o;
      int                ch;
      o  = '0;
      ch = compare_channel(r.reg_offset);
      case (r.action)
         cmst_pkg::ACT_TICK: begin
            tmr_count = tmr_count + 64'd1;
            latch_matches();
         end
         cmst_pkg::ACT_READ: begin
            // reads never compare and never change state
            if (r.reg_offset == cmst_pkg::OFS_STATUS)
               o.read_data = 32'(tmr_match & CHAN_MASK);
            else if (r.reg_offset == cmst_pkg::OFS_LOW)
               o.read_data = tmr_count[31:0];
            else if (r.reg_offset == cmst_pkg::OFS_HIGH)
               o.read_data = tmr_count[63:32];
            else if (ch >= 0)
               o.read_data = tmr_compare[ch];
            else
               o.bad_offset = 1'b1;
         end
         cmst_pkg::ACT_WRITE: begin
            // write one to clear; bits above the channel count are ignored
            if (r.reg_offset == cmst_pkg::OFS_STATUS) begin
               tmr_match &= ~r.write_data[3:0] & CHAN_MASK;
               latch_matches();
            end else if (ch >= 0) begin
               tmr_compare[ch] = r.write_data;
               latch_matches();
            end else begin
               // counter words are read only: same as an unmapped offset
               o.bad_offset = 1'b1;
            end
         end
         default: ;  // idle action: nothing moves
      endcase
      o.irq_lines = tmr_match & CHAN_MASK;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // Drives one request and returns once it is taken. Valid is left high so
   // back-to-back requests never lower and raise it in the same step; the
   // next call lowers it only for an idle gap, and the end of the run does too.
   task automatic send_request(input cmst_pkg::action_type act, input logic [11:0] ofs,
                               input logic [31:0] wdata);
      cmst_pkg::req_type r;
      r.action     = act;
      r.reg_offset = ofs;
      r.write_data = wdata;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted in order, so the scoreboard steps here
      pending_rsp.push_back(timer_predict(r));
   endtask

   // ------------------------------------------------------------------------
   // Response checker and stall driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      cmst_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response with none pending: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_data.read_data);
               fail_count++;
            end
            if (rsp_data.bad_offset !== want.bad_offset) begin
               $error("bad_offset: expected %b, got %b", want.bad_offset,
                      rsp_data.bad_offset);
               fail_count++;
            end
            if (rsp_data.irq_lines !== want.irq_lines) begin
               $error("irq_lines: expected %h, got %h", want.irq_lines, rsp_data.irq_lines);
               fail_count++;
            end
         end
      end
      // one stall update per edge: hold-off first, random stall otherwise
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // everything reads zero after reset; no match latched although the
   // counter and the compares are all zero
   task automatic test_reset_values();
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_STATUS, 32'h0);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_LOW, 32'h0);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_HIGH, 32'h0);
      for (int i = 0; i < CHANNELS; i++)
         send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_CMP0 + 12'(4 * i), 32'hffff_ffff);
   endtask

   // register map: compares read back, read-only counter words, unused
   // channels, misaligned and unmapped offsets, and the idle action
   task automatic test_register_map();
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_CMP0, 32'hffff_ffff);
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_CMP0 + 12'(4 * (CHANNELS - 1)),
                   32'ha5a5_5a5a);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_CMP0, 32'h0);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_CMP0 + 12'(4 * (CHANNELS - 1)),
                   32'h0);
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_LOW, 32'h1234_5678);
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_HIGH, 32'hffff_ffff);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_CMP0 + 12'(4 * CHANNELS), 32'h0);
      send_request(cmst_pkg::ACT_WRITE, 12'hffc, 32'hffff_ffff);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_CMP0 + 12'h001, 32'h0);
      send_request(cmst_pkg::ACT_READ, 12'hfff, 32'h0);
      send_request(cmst_pkg::ACT_IDLE, 12'hfff, 32'hffff_ffff);
   endtask

   // match on tick, status clear, ignored high status bits, match on write
   task automatic test_match_and_clear();
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_CMP0 + 12'd4,
                   tmr_count[31:0] + 32'd2);
      send_request(cmst_pkg::ACT_TICK, 12'h0, 32'h0);
      send_request(cmst_pkg::ACT_TICK, 12'h0, 32'h0);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_STATUS, 32'h0);
      // high bits only: no clear
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_STATUS, 32'hffff_fff0);
      send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_STATUS, 32'hffff_ffff);
      for (int i = 0; i < CHANNELS; i++)
         send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_CMP0 + 12'(4 * i),
                      tmr_count[31:0]);
      send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_STATUS, 32'h0);
   endtask

   // Mostly well-formed traffic: compares set just ahead of the counter so
   // ticks hit them, reads of mapped registers, status clears; the rest is
   // noise over the whole offset range and all actions.
   task automatic test_random_traffic(input int count, input int idle, input int stall);
      int          pick;
      logic [31:0] wdata;
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (count) begin
         pick  = $urandom_range(99);
         wdata = $urandom;
         if (pick < 40)
            send_request(cmst_pkg::ACT_TICK, 12'($urandom), wdata);
         else if (pick < 60)
            send_request(cmst_pkg::ACT_READ, 12'(4 * $urandom_range(2 + CHANNELS)), wdata);
         else if (pick < 78)
            send_request(cmst_pkg::ACT_WRITE,
                         cmst_pkg::OFS_CMP0 + 12'(4 * $urandom_range(CHANNELS - 1)),
                         ($urandom_range(3) == 0) ? wdata
                                                  : tmr_count[31:0] + 32'($urandom_range(6)));
         else if (pick < 85)
            send_request(cmst_pkg::ACT_WRITE, cmst_pkg::OFS_STATUS, wdata);
         else
            send_request(cmst_pkg::action_type'($urandom_range(3)), 12'($urandom), wdata);
      end
   endtask

   // hold responses off for a long stretch while requests keep coming, so
   // both pipe stages fill and the request side stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests++;
      repeat (40) send_request(cmst_pkg::ACT_TICK, 12'h0, 32'h0);
      repeat (10) send_request(cmst_pkg::ACT_READ, cmst_pkg::OFS_LOW, 32'h0);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      tmr_count = '0;
      tmr_match = '0;
      for (int i = 0; i < CHANNELS; i++) tmr_compare[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_register_map();
      test_match_and_clear();
      test_random_traffic(200, 0, 0);
      test_random_traffic(200, 81, 0);
      test_random_traffic(200, 0, 81);
      test_random_traffic(200, 24, 24);
      test_backpressure();

      // drain: nothing left to send, wait out the pending responses
      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
rtl/core/cmst_pkg.sv
rtl/core/compare_match_system_timer_core.sv
test/tb.sv
